// ===== design/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants for the greedy register coloring block: field
// widths, item kind codes and the result of a slot bitmap word scan.
// ----------------------------------------------------------------------------
package grc_pkg;

  // Fixed widths of the item and result fields.
  localparam int NODE_W     = 10;
  localparam int REGIDX_W   = 4;
  localparam int SLOT_OUT_W = 11;

  // The spill slot bitmap is stored as words of this many bits.
  localparam int WORD_W  = 32;
  localparam int WORD_BW = 5;

  // Item kinds.
  localparam logic KIND_ADJ   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Outcome of scanning one bitmap word for a free spill slot.
  typedef struct packed {
    logic               found;
    logic [WORD_BW-1:0] bit_idx;
  } scan_res_t;

endpackage

// ===== design/grc_word_scan.sv =====
// ----------------------------------------------------------------------------
// grc_word_scan
// Finds the lowest free spill slot within one word of the slot bitmap. Slot 0
// and slots beyond the node count are treated as taken.
// ----------------------------------------------------------------------------
module grc_word_scan import grc_pkg::*; #(
  parameter int NUM_NODES = 1024,
  parameter int WA        = 6
) (
  input  logic [WORD_W-1:0] word,
  input  logic [WA-1:0]     word_idx,
  output scan_res_t         res
);

  // Priority pick of the lowest clear bit whose slot number is in range.
  always_comb begin
    int idx;
    res = '0;
    idx = 0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      idx = int'(word_idx) * WORD_W + b;
      if (!word[b] && idx >= 1 && idx <= NUM_NODES) begin
        res.found   = 1'b1;
        res.bit_idx = WORD_BW'(b);
      end
    end
  end

endmodule

// ===== design/greedy_register_coloring_top.sv =====
// ----------------------------------------------------------------------------
// greedy_register_coloring_top
// Greedy graph coloring for register allocation. Nodes arrive as runs of
// adjacency entries; the last entry of a run allocates the node to the lowest
// free register, or else to the lowest spill slot no neighbor holds.
//
//   Channel  Ports                                             Handshake
//   -------  ------------------------------------------------  -------------
//   item in  kind, node, neighbor, neighbor_valid, last        start / busy
//   result   node_out, spilled, register_index, spill_slot     done strobe
//
// An adjacency entry reads the node table for its neighbor and marks the
// neighbor's register; when the neighbor holds a spill slot, it instead marks
// the slot with a bitmap read-modify-write.
// A last entry then makes the register choice; when the node spills, it scans
// the bitmap word by word, a read and a check per word (up to NUM_NODES/32 + 1
// words). If any slot was marked, a sweep then clears the bitmap.
// After reset and after each clear item, a clearing pass runs through the
// node table with busy high.
// The result strobe is held one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module greedy_register_coloring_top import grc_pkg::*; #(
  parameter int NUM_NODES = 1024,
  parameter int NUM_REGS  = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind,
  input  logic [NODE_W-1:0]     node,
  input  logic [NODE_W-1:0]     neighbor,
  input  logic                  neighbor_valid,
  input  logic                  last,
  output logic                  done,
  output logic [NODE_W-1:0]     node_out,
  output logic                  spilled,
  output logic [REGIDX_W-1:0]   register_index,
  output logic [SLOT_OUT_W-1:0] spill_slot
);

  localparam int AW     = $clog2(NUM_NODES);
  localparam int SLOT_W = $clog2(NUM_NODES + 1);
  localparam int REG_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int SW     = (NUM_NODES + WORD_W) / WORD_W;
  localparam int WA     = (SW > 1) ? $clog2(SW) : 1;

  typedef struct packed {
    logic              alloc;
    logic [REG_W-1:0]  rg;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MARK,
    ST_ALLOC,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SWEEP
  } state_t;

  state_t              state;
  logic [AW-1:0]       cnt;
  logic [WA-1:0]       wcnt;
  logic [NODE_W-1:0]   node_q;
  logic                last_q;
  logic                nb_ok_q;
  logic [WA-1:0]       mark_word_q;
  logic [WORD_BW-1:0]  mark_bit_q;
  logic [NUM_REGS-1:0] used_regs;
  logic                slot_marked;

  // Node table: allocated flag, register and spill slot per node.
  entry_t        ntab [NUM_NODES];
  entry_t        ntab_rd;
  logic          nt_we;
  logic [AW-1:0] nt_wa;
  entry_t        nt_wd;

  // Spill slot bitmap for the node being allocated.
  logic [WORD_W-1:0] smap [SW];
  logic [WORD_W-1:0] smap_rd;
  logic [WA-1:0]     sm_ra;
  logic              sm_we;
  logic [WA-1:0]     sm_wa;
  logic [WORD_W-1:0] sm_wd;

  // Allocation decision.
  scan_res_t         scan;
  logic              reg_found;
  logic [REG_W-1:0]  reg_enc;
  logic              fin_valid;
  logic              fin_spill;
  logic [SLOT_W-1:0] fin_slot;
  entry_t            fin_entry;
  logic              node_in_range;

  assign busy = (state != ST_IDLE);

  // Lowest register not marked by any neighbor.
  always_comb begin
    reg_found = 1'b0;
    reg_enc   = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (!used_regs[i]) begin
        reg_found = 1'b1;
        reg_enc   = REG_W'(i);
      end
    end
  end

  grc_word_scan #(
    .NUM_NODES (NUM_NODES),
    .WA        (WA)
  ) u_scan (
    .word     (smap_rd),
    .word_idx (wcnt),
    .res      (scan)
  );

  // A node is finished on a free register, a free slot, or the last word.
  always_comb begin
    fin_spill = (state == ST_SRCH_CHK);
    fin_valid = ((state == ST_ALLOC) && reg_found) ||
                ((state == ST_SRCH_CHK) && (scan.found || wcnt == WA'(SW - 1)));
    fin_slot  = scan.found ? SLOT_W'(int'(wcnt) * WORD_W + int'(scan.bit_idx))
                           : SLOT_W'(NUM_NODES);
    fin_entry.alloc = 1'b1;
    fin_entry.rg    = fin_spill ? '0 : reg_enc;
    fin_entry.slot  = fin_spill ? fin_slot : '0;
    node_in_range   = int'(node_q) < NUM_NODES;
  end

  // Node table write port: clearing pass or the finished node.
  always_comb begin
    nt_we = 1'b0;
    nt_wa = cnt;
    nt_wd = '0;
    if (state == ST_CLEAR) begin
      nt_we = 1'b1;
    end else if (fin_valid) begin
      nt_we = node_in_range;
      nt_wa = AW'(node_q);
      nt_wd = fin_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (nt_we) begin
      ntab[nt_wa] <= nt_wd;
    end
    ntab_rd <= ntab[AW'(neighbor)];
  end

  // Bitmap ports: mark read in lookup, scan reads, mark writes, and zero writes.
  always_comb begin
    sm_ra = wcnt;
    if (state == ST_LOOKUP) begin
      sm_ra = WA'(ntab_rd.slot >> WORD_BW);
    end
    sm_we = 1'b0;
    sm_wa = wcnt;
    sm_wd = '0;
    unique case (state)
      ST_CLEAR: begin
        sm_we = int'(cnt) < SW;
        sm_wa = WA'(cnt);
      end
      ST_MARK: begin
        sm_we = 1'b1;
        sm_wa = mark_word_q;
        sm_wd = smap_rd | (WORD_W'(1) << mark_bit_q);
      end
      ST_SWEEP: begin
        sm_we = 1'b1;
      end
      default: begin
        sm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      smap[sm_wa] <= sm_wd;
    end
    smap_rd <= smap[sm_ra];
  end

  // Sequencer: state, mark accumulators and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      wcnt        <= '0;
      used_regs   <= '0;
      slot_marked <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          used_regs   <= '0;
          slot_marked <= 1'b0;
          cnt         <= cnt + 1'b1;
          if (cnt == AW'(NUM_NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (kind == KIND_CLEAR) begin
              cnt   <= '0;
              state <= ST_CLEAR;
            end else begin
              node_q  <= node;
              last_q  <= last;
              nb_ok_q <= neighbor_valid && (int'(neighbor) < NUM_NODES);
              state   <= ST_LOOKUP;
            end
          end
        end
        ST_LOOKUP: begin
          if (nb_ok_q && ntab_rd.alloc && ntab_rd.slot != '0) begin
            mark_word_q <= WA'(ntab_rd.slot >> WORD_BW);
            mark_bit_q  <= WORD_BW'(ntab_rd.slot);
            state       <= ST_MARK;
          end else begin
            if (nb_ok_q && ntab_rd.alloc && int'(ntab_rd.rg) < NUM_REGS) begin
              used_regs[ntab_rd.rg] <= 1'b1;
            end
            state <= last_q ? ST_ALLOC : ST_IDLE;
          end
        end
        ST_MARK: begin
          slot_marked <= 1'b1;
          state       <= last_q ? ST_ALLOC : ST_IDLE;
        end
        ST_ALLOC: begin
          wcnt <= '0;
          if (!reg_found) begin
            state <= ST_SRCH_RD;
          end
        end
        ST_SRCH_RD: begin
          state <= ST_SRCH_CHK;
        end
        ST_SRCH_CHK: begin
          if (!fin_valid) begin
            wcnt  <= wcnt + 1'b1;
            state <= ST_SRCH_RD;
          end else begin
            wcnt <= '0;
          end
        end
        ST_SWEEP: begin
          wcnt <= wcnt + 1'b1;
          if (wcnt == WA'(SW - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Finished node: emit the result and drop the per-node marks.
      if (fin_valid) begin
        done           <= 1'b1;
        node_out       <= node_q;
        spilled        <= fin_spill;
        register_index <= fin_spill ? '0 : REGIDX_W'(reg_enc);
        spill_slot     <= fin_spill ? SLOT_OUT_W'(fin_slot) : '0;
        used_regs      <= '0;
        slot_marked    <= 1'b0;
        state          <= slot_marked ? ST_SWEEP : ST_IDLE;
      end
    end
  end

  // Every accepted item raises busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result is only strobed when the block was busy in the cycle before.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // A result carries either a register or a spill slot, never both.
  a_result_form: assert property (@(posedge clk) disable iff (rst)
    done |-> (spilled ? (register_index == '0) : (spill_slot == '0)))
    else $error("result carries both a register and a slot");

  // The per-node marks are dropped when a node is finished.
  a_marks_cleared: assert property (@(posedge clk) disable iff (rst)
    done |-> (used_regs == '0 && !slot_marked))
    else $error("marks survived a finished node");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Greedy register coloring testbench
// Feeds adjacency runs and clear items to the allocator, predicts every
// register or spill slot choice in a behavioral coloring model, and compares
// each result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import grc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_NODES  = 1024;
  localparam int NUM_REGS   = 11;
  localparam int ITEM_COUNT = 1850;
  localparam int STALL_MAX  = 6000;
  localparam int DRAIN_WAIT = 1100;

  // One adjacency or clear item, with the sender's pacing for it.
  typedef struct packed {
    logic                kind;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   neighbor;
    logic                neighbor_valid;
    logic                last;
    logic [6:0]          idle_pct;
    logic                wait_empty;
  } adj_item_t;

  // One allocation choice as the block reports it.
  typedef struct packed {
    logic [NODE_W-1:0]     node;
    logic                  spilled;
    logic [REGIDX_W-1:0]   reg_idx;
    logic [SLOT_OUT_W-1:0] slot;
  } color_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  kind = KIND_ADJ;
  logic [NODE_W-1:0]     node = '0;
  logic [NODE_W-1:0]     neighbor = '0;
  logic                  neighbor_valid = 1'b0;
  logic                  last = 1'b0;
  logic                  done;
  logic [NODE_W-1:0]     node_out;
  logic                  spilled;
  logic [REGIDX_W-1:0]   register_index;
  logic [SLOT_OUT_W-1:0] spill_slot;

  adj_item_t pending_items[$];
  color_t    expected_colors[$];
  int        error_count = 0;
  int        stall_cycles = 0;
  int        item_total = 0;
  logic      hold_next = 1'b0;

  // Coloring state of the model.
  bit                    is_allocated [NUM_NODES];
  logic [REGIDX_W-1:0]   reg_of       [NUM_NODES];
  logic [SLOT_OUT_W-1:0] slot_of      [NUM_NODES];
  bit                    slot_taken   [NUM_NODES+1];
  logic [NUM_REGS-1:0]   regs_taken;

  greedy_register_coloring_top #(
    .NUM_NODES(NUM_NODES),
    .NUM_REGS (NUM_REGS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .node          (node),
    .neighbor      (neighbor),
    .neighbor_valid(neighbor_valid),
    .last          (last),
    .done          (done),
    .node_out      (node_out),
    .spilled       (spilled),
    .register_index(register_index),
    .spill_slot    (spill_slot)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clears the per-node marks gathered from the neighbors.
  function automatic void clear_marks();
    int i;
    regs_taken = '0;
    for (i = 0; i <= NUM_NODES; i++) slot_taken[i] = 1'b0;
  endfunction

  // Applies one accepted item to the coloring model and records the choice
  // that a last entry produces.
  function automatic void color_entry(input adj_item_t it);
    color_t c;
    int     i;
    bit     found;
    if (it.kind == KIND_CLEAR) begin
      for (i = 0; i < NUM_NODES; i++) is_allocated[i] = 1'b0;
      clear_marks();
    end else begin
      if (it.neighbor_valid && is_allocated[it.neighbor]) begin
        if (slot_of[it.neighbor] != 0) slot_taken[slot_of[it.neighbor]] = 1'b1;
        else if (reg_of[it.neighbor] < NUM_REGS) regs_taken[reg_of[it.neighbor]] = 1'b1;
      end
      if (it.last) begin
        c = '0;
        c.node = it.node;
        found = 1'b0;
        for (i = 0; i < NUM_REGS && !found; i++) begin
          if (!regs_taken[i]) begin
            c.reg_idx = REGIDX_W'(i);
            found = 1'b1;
          end
        end
        // With every register taken, the lowest free slot wins; a full bitmap
        // saturates at the top slot.
        if (!found) begin
          c.spilled = 1'b1;
          c.slot = SLOT_OUT_W'(NUM_NODES);
          for (i = NUM_NODES; i >= 1; i--) begin
            if (!slot_taken[i]) c.slot = SLOT_OUT_W'(i);
          end
        end
        is_allocated[it.node] = 1'b1;
        reg_of[it.node] = c.reg_idx;
        slot_of[it.node] = c.slot;
        clear_marks();
        expected_colors.push_back(c);
      end
    end
  endfunction

  // Queues one item; the sender's idle rate follows the phase of the run.
  task automatic push_item(input logic k, input logic [NODE_W-1:0] nd,
                           input logic [NODE_W-1:0] nb, input logic nbv,
                           input logic lst);
    adj_item_t it;
    it.kind = k;
    it.node = nd;
    it.neighbor = nb;
    it.neighbor_valid = nbv;
    it.last = lst;
    case (item_total * 4 / ITEM_COUNT)
      0:       it.idle_pct = 7'd0;
      1:       it.idle_pct = 7'd76;
      2:       it.idle_pct = 7'd0;
      default: it.idle_pct = 7'd18;
    endcase
    it.wait_empty = hold_next;
    hold_next = 1'b0;
    pending_items.push_back(it);
    item_total++;
  endtask

  // Driver: presents the head of the pending queue and holds it until taken.
  always @(posedge clk) begin : drive_items
    adj_item_t head;
    bit        go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) color_entry(pending_items.pop_front());
      if (!start || !busy) begin
        go = 1'b0;
        if (pending_items.size() != 0) begin
          head = pending_items[0];
          go = ($urandom_range(99) >= head.idle_pct) &&
               (!head.wait_empty || expected_colors.size() == 0);
        end
        if (go) begin
          kind <= head.kind;
          node <= head.node;
          neighbor <= head.neighbor;
          neighbor_valid <= head.neighbor_valid;
          last <= head.last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result strobe against the oldest prediction.
  always @(posedge clk) begin : check_colors
    color_t want;
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected result: node_out %0d spilled %0b register_index %0d spill_slot %0d",
               node_out, spilled, register_index, spill_slot);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        if (node_out !== want.node) begin
          $error("node_out: expected %0d, actual %0d", want.node, node_out);
          error_count++;
        end
        if (spilled !== want.spilled) begin
          $error("spilled: expected %0b, actual %0b", want.spilled, spilled);
          error_count++;
        end
        if (register_index !== want.reg_idx) begin
          $error("register_index: expected %0d, actual %0d", want.reg_idx, register_index);
          error_count++;
        end
        if (spill_slot !== want.slot) begin
          $error("spill_slot: expected %0d, actual %0d", want.slot, spill_slot);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("greedy_register_coloring_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [NODE_W-1:0] pool [32];
    int                pool_n;
    int                density;
    int                k;
    int                j;
    int                n;

    for (k = 0; k < NUM_NODES; k++) begin
      is_allocated[k] = 1'b0;
      reg_of[k] = '0;
      slot_of[k] = '0;
    end
    clear_marks();

    // Directed: empty runs, unallocated and invalid neighbors, a node that
    // changes within a run, a node that is its own neighbor, and clears.
    push_item(KIND_CLEAR, 10'h3FF, 10'h3FF, 1'b1, 1'b1);
    push_item(KIND_ADJ, 10'd0, 10'h3FF, 1'b0, 1'b1);
    push_item(KIND_ADJ, 10'h3FF, 10'd0, 1'b1, 1'b1);
    push_item(KIND_ADJ, 10'd5, 10'h3FF, 1'b1, 1'b0);
    push_item(KIND_ADJ, 10'd5, 10'd0, 1'b1, 1'b0);
    push_item(KIND_ADJ, 10'd5, 10'd777, 1'b1, 1'b1);
    push_item(KIND_ADJ, 10'd9, 10'd0, 1'b1, 1'b0);
    push_item(KIND_ADJ, 10'd10, 10'd5, 1'b1, 1'b1);
    push_item(KIND_ADJ, 10'd0, 10'd0, 1'b1, 1'b1);
    push_item(KIND_ADJ, 10'h3FF, 10'h3FF, 1'b1, 1'b1);
    push_item(KIND_ADJ, 10'h2AA, 10'h3FF, 1'b0, 1'b0);
    push_item(KIND_ADJ, 10'h2AA, 10'h155, 1'b0, 1'b1);
    push_item(KIND_ADJ, 10'h155, 10'h2AA, 1'b1, 1'b1);
    push_item(KIND_CLEAR, 10'h000, 10'h000, 1'b0, 1'b0);
    push_item(KIND_ADJ, 10'h3FF, 10'd0, 1'b1, 1'b1);
    push_item(KIND_ADJ, 10'd0, 10'h3FF, 1'b1, 1'b1);
    hold_next = 1'b1;

    // Random: mostly dense interference graphs over a small pool of nodes,
    // so registers run out and spill slots get reused; the rest is noise.
    while (item_total < ITEM_COUNT) begin
      if ($urandom_range(7) == 0) hold_next = 1'b1;
      if ($urandom_range(99) < 80) begin
        pool_n = $urandom_range(28, 4);
        density = $urandom_range(100, 55);
        if ($urandom_range(1)) begin
          push_item(KIND_CLEAR, NODE_W'($urandom_range(1023)),
                    NODE_W'($urandom_range(1023)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        for (k = 0; k < pool_n && item_total < ITEM_COUNT; k++) begin
          pool[k] = NODE_W'($urandom_range(1023));
          for (j = 0; j < k; j++) begin
            if ($urandom_range(19) == 0) begin
              push_item(KIND_ADJ, pool[k], NODE_W'($urandom_range(1023)), 1'b0, 1'b0);
            end
            if ($urandom_range(99) < density) begin
              push_item(KIND_ADJ,
                        ($urandom_range(15) == 0) ? NODE_W'($urandom_range(1023)) : pool[k],
                        pool[j], 1'b1, 1'b0);
            end
          end
          if (k > 0 && $urandom_range(1)) begin
            push_item(KIND_ADJ, pool[k], pool[$urandom_range(k - 1)], 1'b1, 1'b1);
          end else begin
            push_item(KIND_ADJ, pool[k], NODE_W'($urandom_range(1023)),
                      1'($urandom_range(1)), 1'b1);
          end
        end
      end else begin
        n = $urandom_range(8, 1);
        for (k = 0; k < n; k++) begin
          push_item(($urandom_range(19) == 0) ? KIND_CLEAR : KIND_ADJ,
                    NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last item and the last result, then let the block settle.
    do @(posedge clk);
    while (pending_items.size() != 0 || start || expected_colors.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_colors.size() != 0) begin
      $error("%0d results never arrived", expected_colors.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("greedy_register_coloring_top regression: pass");
    end else begin
      $display("greedy_register_coloring_top regression: fail");
    end
    $finish;
  end

endmodule
